/* rtl/core/dcd_pkg.sv */
// Shared types, constants and digit helpers for the decimal chunk dedup dictionary.
`timescale 1ns / 1ps
`default_nettype none
package dcd_pkg;

  localparam int unsigned DcdTableDepth  = 1024;
  localparam int unsigned DcdChunkDigits = 64;
  localparam logic [31:0] SeedStart      = 32'd5381;

  typedef enum logic [1:0] {
    STAT_MATCH = 2'd0,
    STAT_ADDED = 2'd1,
    STAT_FULL  = 2'd2
  } dcd_status_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIGIT = 6'b000010,
    ST_CHK   = 6'b000100,
    ST_SRD   = 6'b001000,
    ST_SCMP  = 6'b010000,
    ST_EMIT  = 6'b100000
  } dcd_state_e;

  typedef logic [2:0][3:0] dcd_digits_t;

  // Split a byte into hundreds, tens, ones (index 0 is hundreds).
  function automatic dcd_digits_t split_byte(input logic [7:0] b);
    logic [7:0]  r;
    logic [1:0]  h;
    logic [17:0] prod;
    logic [3:0]  t;
    logic [7:0]  ten_x;
    dcd_digits_t d;
    if (b >= 8'd200) begin
      h = 2'd2;
      r = b - 8'd200;
    end else if (b >= 8'd100) begin
      h = 2'd1;
      r = b - 8'd100;
    end else begin
      h = 2'd0;
      r = b;
    end
    // r < 100: r*205 >> 11 equals r/10
    prod  = 18'(r) * 18'd205;
    t     = prod[14:11];
    ten_x = 8'(t) * 8'd10;
    d[0]  = 4'(h);
    d[1]  = t;
    d[2]  = 4'(r - ten_x);
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/dcd_chunk_acc.sv */
// Chunk accumulator: digit buffer, position, running hash and seed.
`timescale 1ns / 1ps
`default_nettype none
module dcd_chunk_acc import dcd_pkg::*; #(
  parameter int unsigned CHUNK_DIGITS = DcdChunkDigits,
  localparam int unsigned LenW = $clog2(CHUNK_DIGITS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      clear_i,
  input  logic [3:0]                digit_i,
  output logic [LenW-1:0]           pos_o,
  output logic [15:0]               hash_o,
  output logic [31:0]               seed_o,
  output logic [CHUNK_DIGITS*4-1:0] vec_o
);

  logic [LenW-1:0]           pos_q, pos_d;
  logic [15:0]               hash_q, hash_d;
  logic [31:0]               seed_q, seed_d;
  logic [CHUNK_DIGITS*4-1:0] vec_q, vec_d;

  always_comb begin
    pos_d  = pos_q;
    hash_d = hash_q;
    seed_d = seed_q;
    vec_d  = vec_q;
    if (clear_i) begin
      pos_d  = '0;
      hash_d = '0;
      seed_d = SeedStart;
      vec_d  = '0;
    end else if (step_i) begin
      // hash*9 + d and seed*33 + d, as shifts and adds
      hash_d = {hash_q[12:0], 3'b000} + hash_q + 16'(digit_i);
      seed_d = {seed_q[26:0], 5'b00000} + seed_q + 32'(digit_i);
      pos_d  = pos_q + LenW'(1);
      for (int j = 0; j < CHUNK_DIGITS; j++) begin
        if (pos_q == LenW'(j)) vec_d[j*4 +: 4] = digit_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hash_q <= '0;
      seed_q <= SeedStart;
      vec_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      hash_q <= hash_d;
      seed_q <= seed_d;
      vec_q  <= vec_d;
    end
  end

  assign pos_o  = pos_q;
  assign hash_o = hash_q;
  assign seed_o = seed_q;
  assign vec_o  = vec_q;

endmodule
`default_nettype wire

/* rtl/core/dcd_dict.sv */
// Dictionary memory with registered read and the shared entry compare unit.
`timescale 1ns / 1ps
`default_nettype none
module dcd_dict import dcd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = DcdTableDepth,
  parameter int unsigned CHUNK_DIGITS = DcdChunkDigits,
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH),
  localparam int unsigned LenW = $clog2(CHUNK_DIGITS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [IdxW-1:0]           rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [IdxW-1:0]           wr_addr_i,
  input  logic [31:0]               wr_count_i,
  input  logic [15:0]               key_hash_i,
  input  logic [LenW-1:0]           key_len_i,
  input  logic [CHUNK_DIGITS*4-1:0] key_vec_i,
  output logic                      match_o,
  output logic [31:0]               rd_count_o
);

  logic [CHUNK_DIGITS*4-1:0] mem_vec   [TABLE_DEPTH];
  logic [15:0]               mem_hash  [TABLE_DEPTH];
  logic [LenW-1:0]           mem_len   [TABLE_DEPTH];
  logic [31:0]               mem_count [TABLE_DEPTH];

  logic [CHUNK_DIGITS*4-1:0] rd_vec_q;
  logic [15:0]               rd_hash_q;
  logic [LenW-1:0]           rd_len_q;
  logic [31:0]               rd_count_q;

  // Write the key as the entry row; rewrites on a match keep the same digits.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_vec[wr_addr_i]   <= key_vec_i;
      mem_hash[wr_addr_i]  <= key_hash_i;
      mem_len[wr_addr_i]   <= key_len_i;
      mem_count[wr_addr_i] <= wr_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_vec_q   <= mem_vec[rd_addr_i];
      rd_hash_q  <= mem_hash[rd_addr_i];
      rd_len_q   <= mem_len[rd_addr_i];
      rd_count_q <= mem_count[rd_addr_i];
    end
  end

  // Digits past the length are zero on both sides.
  assign match_o    = (rd_hash_q == key_hash_i) && (rd_len_q == key_len_i) &&
                      (rd_vec_q == key_vec_i);
  assign rd_count_o = rd_count_q;

endmodule
`default_nettype wire

/* rtl/core/decimal_chunk_dedup_dictionary.sv */
// Top level: byte intake, search sequencer and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//  out     | source    | out_valid_o/out_ready_i | chunk_id_o, status_o, digit_count_o,
//          |           |                         | chunk_hash_o, chunk_seed_o,
//          |           |                         | occurrences_o, last_result_o
//
// With no chunk closing, a byte beat runs the accept in idle, then a digit
// step and a check step for each of its three digits. Each closed chunk adds
// a linear dictionary search with a memory read, then a compare, per stored
// entry and a final miss step when nothing matches, plus the emit state.
// Reset clears the sequencer, the chunk state and the entry count; the
// dictionary memory needs no clearing pass. in_ready_o is high only in idle.
// A full result register stalls the sequencer in the emit state.
`timescale 1ns / 1ps
`default_nettype none
module decimal_chunk_dedup_dictionary import dcd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = DcdTableDepth,
  parameter int unsigned CHUNK_DIGITS = DcdChunkDigits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  chunk_id_o,
  output logic [1:0]  status_o,
  output logic [6:0]  digit_count_o,
  output logic [15:0] chunk_hash_o,
  output logic [31:0] chunk_seed_o,
  output logic [31:0] occurrences_o,
  output logic        last_result_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LenW  = $clog2(CHUNK_DIGITS + 1);

  dcd_state_e  state_q, state_d;
  dcd_digits_t digits_q, digits_d;
  logic        last_q, last_d;
  logic [1:0]  k_q, k_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [UsedW-1:0] idx_q, idx_d;
  logic [IdxW-1:0]  res_id_q, res_id_d;
  dcd_status_e res_status_q, res_status_d;
  logic [31:0] res_occ_q, res_occ_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [9:0]  out_id_q, out_id_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [6:0]  out_len_q, out_len_d;
  logic [15:0] out_hash_q, out_hash_d;
  logic [31:0] out_seed_q, out_seed_d;
  logic [31:0] out_occ_q, out_occ_d;
  logic        out_last_q, out_last_d;

  // Accumulator and dictionary hookup
  logic                      acc_step, acc_clear;
  logic [LenW-1:0]           acc_pos;
  logic [15:0]               acc_hash;
  logic [31:0]               acc_seed;
  logic [CHUNK_DIGITS*4-1:0] acc_vec;
  logic                      rd_en, wr_en, match;
  logic [IdxW-1:0]           wr_addr;
  logic [31:0]               wr_count, rd_count;
  logic                      table_full, out_free;

  assign table_full = (used_q == UsedW'(TABLE_DEPTH));
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    digits_d     = digits_q;
    last_d       = last_q;
    k_d          = k_q;
    used_d       = used_q;
    idx_d        = idx_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;
    res_occ_d    = res_occ_q;
    acc_step     = 1'b0;
    acc_clear    = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = idx_q[IdxW-1:0];
    wr_count     = 32'd1;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_hash_d   = out_hash_q;
    out_seed_d   = out_seed_q;
    out_occ_d    = out_occ_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          digits_d = split_byte(data_byte_i);
          last_d   = last_byte_i;
          k_d      = 2'd0;
          state_d  = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        acc_step = 1'b1;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        idx_d = '0;
        if (acc_pos == LenW'(CHUNK_DIGITS)) begin
          state_d = ST_SRD;
        end else if (k_q == 2'd2) begin
          state_d = (last_q && acc_pos != '0) ? ST_SRD : ST_IDLE;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_DIGIT;
        end
      end
      ST_SRD: begin
        if (idx_q == used_q) begin
          // Miss: append, or report a full table
          if (table_full) begin
            res_id_d     = '0;
            res_status_d = STAT_FULL;
            res_occ_d    = '0;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = used_q[IdxW-1:0];
            wr_count     = 32'd1;
            used_d       = used_q + UsedW'(1);
            res_id_d     = used_q[IdxW-1:0];
            res_status_d = STAT_ADDED;
            res_occ_d    = 32'd1;
          end
          state_d = ST_EMIT;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_SCMP;
        end
      end
      ST_SCMP: begin
        if (match) begin
          wr_en        = 1'b1;
          wr_count     = (rd_count == '1) ? rd_count : rd_count + 32'd1;
          res_id_d     = idx_q[IdxW-1:0];
          res_status_d = STAT_MATCH;
          res_occ_d    = wr_count;
          state_d      = ST_EMIT;
        end else begin
          idx_d   = idx_q + UsedW'(1);
          state_d = ST_SRD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = 10'(res_id_q);
          out_status_d = res_status_q;
          out_len_d    = 7'(acc_pos);
          out_hash_d   = acc_hash;
          out_seed_d   = acc_seed;
          out_occ_d    = res_occ_q;
          // After a full chunk mid-byte only a final close can follow
          out_last_d   = (k_q == 2'd2) ? 1'b1 : !last_q;
          acc_clear    = 1'b1;
          if (k_q != 2'd2) begin
            k_d     = k_q + 2'd1;
            state_d = ST_DIGIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q     <= digits_d;
    last_q       <= last_d;
    res_id_q     <= res_id_d;
    res_status_q <= res_status_d;
    res_occ_q    <= res_occ_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
    out_hash_q   <= out_hash_d;
    out_seed_q   <= out_seed_d;
    out_occ_q    <= out_occ_d;
    out_last_q   <= out_last_d;
  end

  dcd_chunk_acc #(
    .CHUNK_DIGITS(CHUNK_DIGITS)
  ) u_acc (
    .clk_i,
    .rst_ni,
    .step_i (acc_step),
    .clear_i(acc_clear),
    .digit_i(digits_q[k_q]),
    .pos_o  (acc_pos),
    .hash_o (acc_hash),
    .seed_o (acc_seed),
    .vec_o  (acc_vec)
  );

  dcd_dict #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CHUNK_DIGITS(CHUNK_DIGITS)
  ) u_dict (
    .clk_i,
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[IdxW-1:0]),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_count_i(wr_count),
    .key_hash_i(acc_hash),
    .key_len_i (acc_pos),
    .key_vec_i (acc_vec),
    .match_o   (match),
    .rd_count_o(rd_count)
  );

  assign out_valid_o    = out_valid_q;
  assign chunk_id_o     = out_id_q;
  assign status_o       = out_status_q;
  assign digit_count_o  = out_len_q;
  assign chunk_hash_o   = out_hash_q;
  assign chunk_seed_o   = out_seed_q;
  assign occurrences_o  = out_occ_q;
  assign last_result_o  = out_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && res_status_q == STAT_FULL) |-> table_full)
    else $error("full status with free entries");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIGIT && k_q == 2'd0))
    else $error("accepted beat did not start digit work");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCMP) |-> (idx_q < used_q))
    else $error("compare beyond stored entries");

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the decimal chunk dedup dictionary.
`timescale 1ns / 1ps
module tb;
  import dcd_pkg::*;

  localparam int unsigned Depth    = DcdTableDepth;
  localparam int unsigned ChunkLen = DcdChunkDigits;
  localparam int unsigned StallLimit = 20000;

  typedef struct {
    logic [9:0]  id;
    dcd_status_e status;
    logic [6:0]  len;
    logic [15:0] hash;
    logic [31:0] seed;
    logic [31:0] occ;
    logic        last;
  } chunk_result_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o, out_ready_i;
  logic [9:0]  chunk_id_o;
  logic [1:0]  status_o;
  logic [6:0]  digit_count_o;
  logic [15:0] chunk_hash_o;
  logic [31:0] chunk_seed_o;
  logic [31:0] occurrences_o;
  logic        last_result_o;

  decimal_chunk_dedup_dictionary dut (.*);

  // Dictionary shadow: the bench keeps its own copy of every stored chunk.
  logic [255:0] cur_digits;
  int unsigned  cur_pos;
  logic [15:0]  cur_hash;
  logic [31:0]  cur_seed;
  logic [255:0] dict_digits [Depth];
  logic [15:0]  dict_hash   [Depth];
  logic [6:0]   dict_len    [Depth];
  logic [31:0]  dict_count  [Depth];
  int unsigned  dict_used;

  chunk_result_t expected_q[$];
  int unsigned   mismatches, results_seen, bytes_sent, burst_left;
  int unsigned   n_match, n_added, n_full, n_double;
  int unsigned   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hold reset with every input parked at a known value.
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void clear_chunk();
    cur_digits = '0;
    cur_pos    = 0;
    cur_hash   = '0;
    cur_seed   = SeedStart;
  endfunction

  // Look the closed chunk up in the shadow table and build its result.
  function automatic chunk_result_t close_chunk();
    chunk_result_t r;
    bit found;
    found    = 1'b0;
    r.id     = '0;
    r.status = STAT_FULL;
    r.occ    = '0;
    r.len    = 7'(cur_pos);
    r.hash   = cur_hash;
    r.seed   = cur_seed;
    r.last   = 1'b0;
    for (int unsigned i = 0; i < dict_used && !found; i++) begin
      if (dict_hash[i] == cur_hash && dict_len[i] == 7'(cur_pos) &&
          dict_digits[i] == cur_digits) begin
        if (dict_count[i] != 32'hFFFF_FFFF) dict_count[i]++;
        found    = 1'b1;
        r.id     = 10'(i);
        r.status = STAT_MATCH;
        r.occ    = dict_count[i];
      end
    end
    if (!found && dict_used < Depth) begin
      dict_digits[dict_used] = cur_digits;
      dict_hash[dict_used]   = cur_hash;
      dict_len[dict_used]    = 7'(cur_pos);
      dict_count[dict_used]  = 32'd1;
      r.id     = 10'(dict_used);
      r.status = STAT_ADDED;
      r.occ    = 32'd1;
      dict_used++;
    end
    clear_chunk();
    return r;
  endfunction

  // Split an accepted byte into digits and queue the results it closes.
  function automatic void predict_byte(logic [7:0] b, logic l);
    logic [3:0]    dig [3];
    chunk_result_t got [$];
    dig[0] = 4'(b / 100);
    dig[1] = 4'((b % 100) / 10);
    dig[2] = 4'(b % 10);
    for (int k = 0; k < 3; k++) begin
      if (cur_pos >= ChunkLen) clear_chunk();
      cur_digits[4*cur_pos +: 4] = dig[k];
      cur_hash = cur_hash * 16'd9 + 16'(dig[k]);
      cur_seed = cur_seed * 32'd33 + 32'(dig[k]);
      cur_pos++;
      if (cur_pos == ChunkLen && got.size() < 2) got.push_back(close_chunk());
    end
    if (l) begin
      if (cur_pos > 0 && got.size() < 2) got.push_back(close_chunk());
      clear_chunk();
    end
    if (got.size() > 0) got[got.size()-1].last = 1'b1;
    if (got.size() == 2) n_double++;
    foreach (got[i]) begin
      case (got[i].status)
        STAT_MATCH: n_match++;
        STAT_ADDED: n_added++;
        default:    n_full++;
      endcase
      expected_q.push_back(got[i]);
    end
  endfunction

  // Send one byte beat; open a random gap first when the current burst is spent.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, l);
    bytes_sent++;
  endtask

  // Send a whole stream; the final byte carries the end marker.
  task automatic send_stream(input logic [7:0] s [$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Receiver: rotate between always-ready, random stalls and long stalls.
  int unsigned cyc;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc / 512) % 3)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ((cyc % 37) > 20);
    endcase
  end
  initial cyc = 0;

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d %s: expected %0h, got %0h",
                 $realtime, results_seen, name, exp_v, act_v);
    end
  endtask

  // Check every result beat against the oldest expectation.
  always @(posedge clk_i) begin
    chunk_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] result with nothing expected", $realtime);
      end else begin
        e = expected_q.pop_front();
        report_field("chunk_id", 32'(e.id), 32'(chunk_id_o));
        report_field("status", 32'(e.status), 32'(status_o));
        report_field("digit_count", 32'(e.len), 32'(digit_count_o));
        report_field("chunk_hash", 32'(e.hash), 32'(chunk_hash_o));
        report_field("chunk_seed", e.seed, chunk_seed_o);
        report_field("occurrences", e.occ, occurrences_o);
        report_field("last_result", 32'(e.last), 32'(last_result_o));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout after %0d idle cycles, %0d results pending",
               idle_cycles, expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end
  initial idle_cycles = 0;

  // Byte extremes and digit boundaries, each as a one-byte stream, then 255 and 0 again.
  task automatic test_extremes();
    logic [7:0] vals [$] = '{8'd0, 8'd255, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200,
                              8'd170, 8'd85};
    foreach (vals[i]) send_byte(vals[i], 1'b1);
    send_byte(8'd255, 1'b1);
    send_byte(8'd0, 1'b1);
  endtask

  // A two-byte stream, then a chunk that closes mid-byte, sent twice for a match.
  task automatic test_chunk_split();
    logic [7:0] s [$];
    for (int i = 0; i < 22; i++) s.push_back(8'(i * 11 + 3));
    send_byte(8'd42, 1'b0);
    send_byte(8'd17, 1'b1);
    // 22 bytes hold 66 digits: the full chunk closes on the first digit of
    // the last byte and the two leftover digits close as a short chunk.
    send_stream(s);
    send_stream(s);
    // 21 bytes hold 63 digits, one short of a chunk, closed by the end marker.
    s.pop_back();
    send_stream(s);
  endtask

  // Random streams: mostly replays of a small pool so chunks match, the rest fresh.
  task automatic test_random_streams(input int unsigned n_bytes);
    logic [7:0]  pool [8][$];
    logic [7:0]  s [$];
    int unsigned target;
    for (int p = 0; p < 8; p++) begin
      repeat ($urandom_range(1, 50)) pool[p].push_back(8'($urandom));
    end
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 2) != 0) begin
        s = pool[$urandom_range(0, 7)];
      end else begin
        s.delete();
        repeat ($urandom_range(1, 70)) s.push_back(8'($urandom));
      end
      send_stream(s);
    end
  endtask

  // Fill the table, one-byte chunks first as the cheapest entries, then
  // two-byte chunks; then probe with new and known chunks.
  task automatic test_table_full();
    logic [7:0] s [$];
    for (int v = 0; v < 256 && dict_used < Depth; v++) send_byte(8'(v), 1'b1);
    while (dict_used < Depth) begin
      s = '{8'($urandom), 8'($urandom)};
      send_stream(s);
    end
    repeat (4) begin
      s = '{8'($urandom), 8'($urandom), 8'($urandom)};
      send_stream(s);
    end
    send_byte(8'd255, 1'b1);
    send_byte(8'd0, 1'b1);
  endtask

  initial begin
    mismatches = 0; results_seen = 0; bytes_sent = 0; burst_left = 0;
    n_match = 0; n_added = 0; n_full = 0; n_double = 0;
    dict_used = 0;
    clear_chunk();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    test_extremes();
    test_chunk_split();
    test_random_streams(100);
    test_table_full();
    in_valid_i <= 1'b0;
    // Drain, then leave room for a full-table search before judging.
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 20) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d chunk results (%0d two-result bytes).",
             bytes_sent, results_seen, n_double);
    $display("Outcomes: %0d matched, %0d added, %0d table full; %0d mismatches.",
             n_match, n_added, n_full, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* decimal_chunk_dedup_dictionary.f */
rtl/core/dcd_pkg.sv
rtl/core/dcd_chunk_acc.sv
rtl/core/dcd_dict.sv
rtl/core/decimal_chunk_dedup_dictionary.sv
bench/tb.sv
